FILE: rtl/epr_pkg.sv
// Shared types, constants and the arctangent table for the pose-to-rotation pipeline.
package epr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEP_W       = $clog2(TABLE_LEN);
  localparam int NLANE        = 3;
  localparam int LANE_ROLL    = 0;
  localparam int LANE_PITCH   = 1;
  localparam int LANE_YAW     = 2;

  typedef logic signed [33:0] cxy_t;
  typedef logic signed [31:0] q30_t;

  localparam cxy_t INV_GAIN = 34'sd652032875;
  localparam cxy_t ONE_XY   = 34'sd1073741824;
  localparam q30_t ONE_Q30  = 32'sd1073741824;

  typedef struct packed {
    cxy_t              x;
    cxy_t              y;
    logic signed [31:0] z;
    logic [1:0]        quad;
  } lane_t;

  typedef struct packed {
    q30_t c;
    q30_t s;
  } sc_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        planar;
  } side_t;

  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051D;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/epr_cordic_stage.sv
// One CORDIC micro-rotation for one angle lane.
module epr_cordic_stage (
  input  logic [epr_pkg::STEP_W-1:0] step_idx,
  input  epr_pkg::lane_t             lane_in,
  output epr_pkg::lane_t             lane_out
);
  import epr_pkg::*;

  cxy_t               x_sh;
  cxy_t               y_sh;
  logic signed [31:0] ang;

  always_comb begin
    x_sh          = $signed(lane_in.x) >>> step_idx;
    y_sh          = $signed(lane_in.y) >>> step_idx;
    ang           = $signed(atan_q30(step_idx));
    lane_out.quad = lane_in.quad;
    // rotate toward zero residual angle
    if (!lane_in.z[31]) begin
      lane_out.x = $signed(lane_in.x) - y_sh;
      lane_out.y = $signed(lane_in.y) + x_sh;
      lane_out.z = $signed(lane_in.z) - ang;
    end else begin
      lane_out.x = $signed(lane_in.x) + y_sh;
      lane_out.y = $signed(lane_in.y) - x_sh;
      lane_out.z = $signed(lane_in.z) + ang;
    end
  end

endmodule

FILE: rtl/epr_cordic_pipe.sv
// Pipelined sine/cosine of three angles: quadrant split, CORDIC stages, fold-back.
module epr_cordic_pipe (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  valid_in,
  output logic                                  ready_up,
  input  logic [epr_pkg::NLANE-1:0][15:0]       ang_in,
  input  epr_pkg::side_t                        side_in,
  output logic                                  valid_out,
  input  logic                                  ready_dn,
  output epr_pkg::sc_t [epr_pkg::NLANE-1:0]     sc_out,
  output epr_pkg::side_t                        side_out
);
  import epr_pkg::*;

  localparam int NST = CORDIC_STEPS + 2;   // front, CORDIC steps, fold-back
  localparam int LAST = NST - 1;

  logic [NST:0]   en;
  logic [NST-1:0] valid_r;
  lane_t          lane_r   [CORDIC_STEPS+1][NLANE];
  lane_t          lane_nxt [CORDIC_STEPS+1][NLANE];
  side_t          side_r   [NST];
  sc_t            sc_r     [NLANE];
  sc_t            sc_nxt   [NLANE];

  assign en[NST] = ready_dn;
  genvar k, l;
  generate
    for (k = 0; k < NST; k++) begin : g_en
      assign en[k] = ~valid_r[k] | en[k+1];
    end
  endgenerate
  assign ready_up = en[0];

  // quadrant split
  generate
    for (l = 0; l < NLANE; l++) begin : g_front
      logic [15:0] sum16;
      logic [1:0]  q;
      logic [15:0] rb;
      always_comb begin
        sum16 = ang_in[l] + 16'h2000;
        q     = sum16[15:14];
        rb    = ang_in[l] - {q, 14'd0};
        lane_nxt[0][l].x    = INV_GAIN;
        lane_nxt[0][l].y    = '0;
        lane_nxt[0][l].z    = $signed({rb, 16'd0});
        lane_nxt[0][l].quad = q;
      end
    end

    for (k = 1; k <= CORDIC_STEPS; k++) begin : g_step
      for (l = 0; l < NLANE; l++) begin : g_lane
        epr_cordic_stage u_stage (
          .step_idx (STEP_W'(k - 1)),
          .lane_in  (lane_r[k-1][l]),
          .lane_out (lane_nxt[k][l])
        );
      end
    end

    for (k = 0; k <= CORDIC_STEPS; k++) begin : g_reg
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (en[k]) begin
          valid_r[k] <= (k == 0) ? valid_in : valid_r[(k == 0) ? 0 : k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en[k]) begin
          lane_r[k] <= lane_nxt[k];
          side_r[k] <= (k == 0) ? side_in : side_r[(k == 0) ? 0 : k-1];
        end
      end
    end

    // clamp, fold back by quadrant, force roll and pitch in planar mode
    for (l = 0; l < NLANE; l++) begin : g_post
      cxy_t xc, yc;
      q30_t xs, ys;
      always_comb begin
        xc = lane_r[CORDIC_STEPS][l].x;
        yc = lane_r[CORDIC_STEPS][l].y;
        if (xc > ONE_XY)       xc = ONE_XY;
        else if (xc < -ONE_XY) xc = -ONE_XY;
        if (yc > ONE_XY)       yc = ONE_XY;
        else if (yc < -ONE_XY) yc = -ONE_XY;
        xs = xc[31:0];
        ys = yc[31:0];
        unique case (lane_r[CORDIC_STEPS][l].quad)
          2'd0: begin sc_nxt[l].c = xs;  sc_nxt[l].s = ys;  end
          2'd1: begin sc_nxt[l].c = -ys; sc_nxt[l].s = xs;  end
          2'd2: begin sc_nxt[l].c = -xs; sc_nxt[l].s = -ys; end
          2'd3: begin sc_nxt[l].c = ys;  sc_nxt[l].s = -xs; end
        endcase
        if (side_r[CORDIC_STEPS].planar && l != LANE_YAW) begin
          sc_nxt[l].c = ONE_Q30;
          sc_nxt[l].s = '0;
        end
      end
      assign sc_out[l] = sc_r[l];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[LAST] <= 1'b0;
    end else if (en[LAST]) begin
      valid_r[LAST] <= valid_r[LAST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      sc_r         <= sc_nxt;
      side_r[LAST] <= side_r[LAST-1];
    end
  end

  assign valid_out = valid_r[LAST];
  assign side_out  = side_r[LAST];

endmodule

FILE: rtl/epr_matrix.sv
// Three-stage rotation matrix build: pitch/roll products, entry products, sum and round.
module epr_matrix (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              valid_in,
  output logic                              ready_up,
  input  epr_pkg::sc_t [epr_pkg::NLANE-1:0] sc_in,
  input  epr_pkg::side_t                    side_in,
  output logic                              valid_out,
  input  logic                              ready_dn,
  output logic [8:0][15:0]                  m_out,
  output epr_pkg::side_t                    side_out
);
  import epr_pkg::*;

  function automatic logic [15:0] to_q14(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd35184372088832) >>> 46;
    if (r < -64'sd16384)     return 16'hC000;
    else if (r > 64'sd16384) return 16'h4000;
    else                     return r[15:0];
  endfunction

  logic en1, en2, en3;
  logic v1_r, v2_r, v3_r;

  // stage 1
  q30_t  cr1_r, sr1_r, cp1_r, sp1_r, cy1_r, sy1_r, spsr_r, spcr_r;
  side_t side1_r;
  logic signed [63:0] t_spsr, t_spcr;

  // stage 2
  logic signed [63:0] p_cycp_r, p_cyspsr_r, p_sycr_r, p_cyspcr_r, p_sysr_r, p_sycp_r;
  logic signed [63:0] p_syspsr_r, p_cycr_r, p_syspcr_r, p_cysr_r, p_cpsr_r, p_cpcr_r;
  logic signed [63:0] p_m20_r;
  side_t side2_r;
  q30_t  nsp;

  // stage 3
  logic [8:0][15:0] m_r;
  side_t side3_r;

  assign en3      = ~v3_r | ready_dn;
  assign en2      = ~v2_r | en3;
  assign en1      = ~v1_r | en2;
  assign ready_up = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= valid_in;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_comb begin
    t_spsr = sc_in[LANE_PITCH].s * sc_in[LANE_ROLL].s + 64'sd536870912;
    t_spcr = sc_in[LANE_PITCH].s * sc_in[LANE_ROLL].c + 64'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cr1_r   <= sc_in[LANE_ROLL].c;
      sr1_r   <= sc_in[LANE_ROLL].s;
      cp1_r   <= sc_in[LANE_PITCH].c;
      sp1_r   <= sc_in[LANE_PITCH].s;
      cy1_r   <= sc_in[LANE_YAW].c;
      sy1_r   <= sc_in[LANE_YAW].s;
      spsr_r  <= t_spsr[61:30];
      spcr_r  <= t_spcr[61:30];
      side1_r <= side_in;
    end
  end

  assign nsp = -sp1_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      p_cycp_r   <= cy1_r * cp1_r;
      p_cyspsr_r <= cy1_r * spsr_r;
      p_sycr_r   <= sy1_r * cr1_r;
      p_cyspcr_r <= cy1_r * spcr_r;
      p_sysr_r   <= sy1_r * sr1_r;
      p_sycp_r   <= sy1_r * cp1_r;
      p_syspsr_r <= sy1_r * spsr_r;
      p_cycr_r   <= cy1_r * cr1_r;
      p_syspcr_r <= sy1_r * spcr_r;
      p_cysr_r   <= cy1_r * sr1_r;
      p_cpsr_r   <= cp1_r * sr1_r;
      p_cpcr_r   <= cp1_r * cr1_r;
      p_m20_r    <= $signed({{2{nsp[31]}}, nsp, 30'd0});
      side2_r    <= side1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      m_r[0]  <= to_q14(p_cycp_r);
      m_r[1]  <= to_q14(p_cyspsr_r - p_sycr_r);
      m_r[2]  <= to_q14(p_cyspcr_r + p_sysr_r);
      m_r[3]  <= to_q14(p_sycp_r);
      m_r[4]  <= to_q14(p_syspsr_r + p_cycr_r);
      m_r[5]  <= to_q14(p_syspcr_r - p_cysr_r);
      m_r[6]  <= to_q14(p_m20_r);
      m_r[7]  <= to_q14(p_cpsr_r);
      m_r[8]  <= to_q14(p_cpcr_r);
      side3_r <= side2_r;
    end
  end

  assign valid_out = v3_r;
  assign m_out     = m_r;
  assign side_out  = side3_r;

endmodule

FILE: rtl/euler_pose_to_rotation.sv
// Top level: ZYX Euler pose to rotation matrix plus translation.
//
//  channel | direction | payload (low bits first)
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle
//  out_    | master    | m00..m22, out_x, out_y, out_z
//  cfg_    | write     | planar_mode
//
// One word enters per cycle while in_tready is high; each word passes through one
// register stage per CORDIC iteration plus the quadrant split, fold-back and
// three matrix stages.
// Reset clears all valid bits and planar_mode; payload registers are not reset.
// A stall on out_ only backs up stages that hold a word: empty stages keep
// filling, so in_tready stays high while any bubble remains in the pipeline.
module euler_pose_to_rotation (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], roll_angle[111:96],
  // pitch_angle[127:112], yaw_angle[143:128]
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // m00[15:0], m01, m02, m10, m11, m12, m20, m21, m22[143:128],
  // out_x[175:144], out_y[207:176], out_z[239:208]
  output logic [239:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data
);
  import epr_pkg::*;

  logic planar_mode_r;

  logic [NLANE-1:0][15:0]  ang;
  side_t                   side_in;
  logic                    cp_valid, cp_ready;
  sc_t [NLANE-1:0]         sc;
  side_t                   side_mid;
  logic [8:0][15:0]        m;
  side_t                   side_out;

  // hold the planar-mode register; writes must arrive only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planar_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      planar_mode_r <= cfg_wr_data;
    end
  end

  // unpack the input word; drop z at entry in planar mode
  assign ang[LANE_ROLL]  = in_tdata[111:96];
  assign ang[LANE_PITCH] = in_tdata[127:112];
  assign ang[LANE_YAW]   = in_tdata[143:128];
  assign side_in.px      = in_tdata[31:0];
  assign side_in.py      = in_tdata[63:32];
  assign side_in.pz      = planar_mode_r ? 32'd0 : in_tdata[95:64];
  assign side_in.planar  = planar_mode_r;

  epr_cordic_pipe u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_tvalid),
    .ready_up  (in_tready),
    .ang_in    (ang),
    .side_in   (side_in),
    .valid_out (cp_valid),
    .ready_dn  (cp_ready),
    .sc_out    (sc),
    .side_out  (side_mid)
  );

  epr_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (cp_valid),
    .ready_up  (cp_ready),
    .sc_in     (sc),
    .side_in   (side_mid),
    .valid_out (out_tvalid),
    .ready_dn  (out_tready),
    .m_out     (m),
    .side_out  (side_out)
  );

  assign out_tdata = {side_out.pz, side_out.py, side_out.px, m};

endmodule

FILE: rtl/epr_checker.sv
// Port-level checks for the pose-to-rotation block and their bind.
module epr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [239:0] out_tdata
);

  // no word survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // an empty output means nothing blocks the pipeline
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with empty output");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");

  // matrix entry m00 stays within plus and minus one
  a_m00_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) >= -16'sd16384) &&
                   ($signed(out_tdata[15:0]) <= 16'sd16384))
    else $error("m00 out of range");

endmodule

bind euler_pose_to_rotation epr_checker u_epr_checker (.*);

FILE: tb/pose_checker.sv
// Checker for the pose-to-rotation block: predicts each result word and compares it.
module pose_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [239:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import epr_pkg::*;

  localparam logic [63:0] ATAN_Q30 [TABLE_LEN] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  localparam longint UNIT = 64'sd1 << 30;

  logic [239:0] rotation_queue[$];
  logic         planar_q;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rotation-mode sine/cosine of a binary angle in Q1.30.
  function automatic void angle_sincos(input logic [15:0] ang, output longint c,
                                       output longint s);
    logic [15:0] resid;
    logic [1:0]  quad;
    longint      x, y, z, t;
    quad  = 2'((ang + 16'h2000) >> 14);
    resid = ang - {quad, 14'd0};
    z = longint'($signed(resid)) * 65536;
    x = longint'(INV_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= longint'(ATAN_Q30[i]);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += longint'(ATAN_Q30[i]);
      end
    end
    x = clamp(x, -UNIT, UNIT);
    y = clamp(y, -UNIT, UNIT);
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint round_q14(longint v);
    return clamp((v + (64'sd1 << 45)) >>> 46, -16384, 16384);
  endfunction

  function automatic logic [239:0] predict_pose(logic [143:0] d, logic planar);
    longint cr, sr, cp, sp, cy, sy, spsr, spcr;
    longint m[9];
    logic [239:0] r;
    angle_sincos(d[143:128], cy, sy);
    if (planar) begin
      cr = UNIT; sr = 0; cp = UNIT; sp = 0;
    end else begin
      angle_sincos(d[111:96], cr, sr);
      angle_sincos(d[127:112], cp, sp);
    end
    spsr = (sp * sr + (64'sd1 << 29)) >>> 30;
    spcr = (sp * cr + (64'sd1 << 29)) >>> 30;
    m[0] = round_q14(cy * cp);
    m[1] = round_q14(cy * spsr - sy * cr);
    m[2] = round_q14(cy * spcr + sy * sr);
    m[3] = round_q14(sy * cp);
    m[4] = round_q14(sy * spsr + cy * cr);
    m[5] = round_q14(sy * spcr - cy * sr);
    m[6] = round_q14(-sp * UNIT);
    m[7] = round_q14(cp * sr);
    m[8] = round_q14(cp * cr);
    for (int j = 0; j < 9; j++) r[j*16 +: 16] = m[j][15:0];
    r[175:144] = d[31:0];
    r[207:176] = d[63:32];
    r[239:208] = planar ? 32'd0 : d[95:64];
    return r;
  endfunction

  always @(posedge clk) begin
    logic [239:0] want;
    if (!rst_n) begin
      planar_q   <= 1'b0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_tvalid && in_tready) rotation_queue.push_back(predict_pose(in_tdata, planar_q));
      if (cfg_wr_en) planar_q <= cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (rotation_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %h", out_tdata);
        end else begin
          want = rotation_queue.pop_front();
          if (want !== out_tdata) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              for (int f = 0; f < 9; f++)
                if (want[f*16 +: 16] !== out_tdata[f*16 +: 16])
                  $display("m%0d%0d expected %0d got %0d", f / 3, f % 3,
                           $signed(want[f*16 +: 16]), $signed(out_tdata[f*16 +: 16]));
              for (int f = 0; f < 3; f++)
                if (want[144+f*32 +: 32] !== out_tdata[144+f*32 +: 32])
                  $display("translation %0d expected %h got %h", f,
                           want[144+f*32 +: 32], out_tdata[144+f*32 +: 32]);
            end
          end
        end
      end
      pending <= rotation_queue.size();
    end
  end
endmodule

FILE: tb/testbench.sv
// Top of the pose-to-rotation testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 21;
  localparam int CYCLE_LIMIT = 200000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [239:0] out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_wr_data = 1'b0;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;

  always #5 clk = ~clk;

  euler_pose_to_rotation u_top (.*);

  pose_checker u_checker (.*);

  // Abort on a hung pipeline.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall for a random stretch before each word, sometimes not at all.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Present one word and hold it until it is taken.
  task automatic send_pose(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
                           input logic [15:0] roll, input logic [15:0] pitch,
                           input logic [15:0] yaw, input bit bursty);
    int gap;
    gap = bursty ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yaw, pitch, roll, pz, py, px};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    logic [15:0] ang[3];
    bit          bursty;
    for (int i = 0; i < count; i++) begin
      bursty = (i / 40) % 3 == 0;
      // mostly arbitrary angles, some near quadrant boundaries
      for (int a = 0; a < 3; a++)
        ang[a] = ($urandom_range(0, 4) == 0)
                 ? 16'($urandom_range(0, 3) * 16'h2000 + $urandom_range(0, 4) - 2)
                 : 16'($urandom);
      send_pose($urandom, $urandom, $urandom, ang[0], ang[1], ang[2], bursty);
    end
  endtask

  // Drain the pipeline, then write the planar register.
  task automatic set_planar(input logic mode);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [15:0] edge_angle[8];
    edge_angle = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                   16'h1FFF, 16'h2000, 16'h7FFF, 16'hFFFF};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: angle extremes and quadrant edges on each axis, extreme translations.
    for (int k = 0; k < 8; k++)
      send_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                edge_angle[k], edge_angle[(k + 3) % 8], edge_angle[(k + 5) % 8], 1'b1);
    send_pose(32'h0, 32'h0, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_pose(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_random(250);

    set_planar(1'b1);
    for (int k = 0; k < 8; k++)
      send_pose($urandom, $urandom, 32'h7FFF_FFFF, edge_angle[k], edge_angle[7 - k],
                edge_angle[k], 1'b0);
    send_random(250);

    set_planar(1'b0);
    send_random(200);

    // Hold off until every result is back, then resume.
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    send_random(200);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
